// ----- rtl/phpf_pkg.sv -----
// shared types and constants for the packet header prefix framer
// no dependencies; used by the core, phpf_front, phpf_back and the testbench
package phpf_pkg;

   // default storage for the access code
   localparam int MAX_CODE_BITS_DEF = 64;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_ACCESS_CODE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_BITS   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_PREFIX_MODE = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_LOOP_LENGTH = CSR_INDEX_W'(3);

   // prefix mode codes
   typedef enum logic [2:0] {
      MODE_CLEAR    = 3'd0,
      MODE_INTERF   = 3'd1,
      MODE_CLR_LOOP = 3'd2,
      MODE_INT_LOOP = 3'd3,
      MODE_ALT_LOOP = 3'd4
   } mode_type;

   // access code byte count, enough for up to 8 code bytes
   localparam int NBYTES_W = 4;

   // header bytes that follow the access code
   localparam int HDR_FIXED_BYTES = 8;

   // one classified transaction handed from front to back
   typedef struct packed {
      logic [7:0]          data_byte;
      logic                first;
      logic                last;
      logic [15:0]         packet_length;
      logic [NBYTES_W-1:0] code_bytes;
      logic [7:0]          index_byte;
      logic [7:0]          size_byte;
      logic [15:0]         count;
   } phpf_cmd_type;

endpackage

// ----- rtl/packet_header_prefix_framer_core.sv -----
// top level of the packet header prefix framer: front end, queue, back end
// depends on phpf_pkg, phpf_front, phpf_queue, phpf_back
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  data_byte, first/last marks, length
//   rsp      out        rsp_valid/rsp_ready  out_byte, is_header, packet_end, run_last
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// a payload byte gives one output byte; a first byte gives ceil(bits/8) + 9,
// one byte per cycle out of the back end from the queue head while rsp_ready holds
// first result passes a queue slot, then the output register, before it is offered
// a packet start with counter + 1 at or past twice the loop length runs a
// remainder unit in the front end, req and csr not ready meanwhile
// synchronous reset; rsp stalls back up through the 2-entry queue
module packet_header_prefix_framer_core #(
   parameter int MAX_CODE_BITS = phpf_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_first_of_packet,
   input  logic                             req_last_of_packet,
   input  logic [15:0]                      req_packet_length,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_is_header,
   output logic                             rsp_packet_end,
   output logic                             rsp_run_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [phpf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [phpf_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CODE_PAD_W = ((MAX_CODE_BITS + 7) / 8) * 8;
   localparam int CMD_W      = $bits(phpf_pkg::phpf_cmd_type);
   localparam int ENTRY_W    = CODE_PAD_W + CMD_W;

   logic                   push_valid, push_ready;
   phpf_pkg::phpf_cmd_type push_cmd, q_cmd;
   logic [CODE_PAD_W-1:0]  push_code, q_code;
   logic                   q_valid, q_pop;
   logic [ENTRY_W-1:0]     q_in_data, q_out_data;

   // classify and sequence
   phpf_front #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_first_of_packet (req_first_of_packet),
      .req_last_of_packet  (req_last_of_packet),
      .req_packet_length   (req_packet_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_cmd            (push_cmd),
      .push_code           (push_code)
   );

   // decoupling queue
   assign q_in_data = {push_code, push_cmd};
   assign q_code    = q_out_data[ENTRY_W-1:CMD_W];
   assign q_cmd     = q_out_data[CMD_W-1:0];

   phpf_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (q_in_data),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_data  (q_out_data)
   );

   // byte emission
   phpf_back #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_cmd          (q_cmd),
      .q_code         (q_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_header  (rsp_is_header),
      .rsp_packet_end (rsp_packet_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

// ----- rtl/phpf_front.sv -----
// front end: configuration registers, input accept, header field classification,
// sequence counter and its modulo unit; depends on phpf_pkg
module phpf_front #(
   parameter int  MAX_CODE_BITS = phpf_pkg::MAX_CODE_BITS_DEF,
   localparam int CODE_PAD_W    = ((MAX_CODE_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_first_of_packet,
   input  logic                               req_last_of_packet,
   input  logic [15:0]                        req_packet_length,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [phpf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [phpf_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               push_valid,
   input  logic                               push_ready,
   output phpf_pkg::phpf_cmd_type             push_cmd,
   output logic [CODE_PAD_W-1:0]              push_code
);

   localparam logic [7:0]  INTERF_INDEX = 8'h11;
   localparam logic [7:0]  INTERF_SIZE  = 8'hff;
   localparam logic [15:0] NO_COUNT     = 16'hffff;
   localparam int          SEQ_W        = 16;
   localparam logic [4:0]  RED_STEPS    = 5'(SEQ_W + 1);

   // configuration registers
   logic [MAX_CODE_BITS-1:0] code_ff, code_in;
   logic [6:0]               code_bits_ff, code_bits_in;
   logic [2:0]               mode_ff, mode_in;
   logic [15:0]              loop_len_ff, loop_len_in;

   // sequence state
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic             phase_ff, phase_in;

   // modulo unit, one remainder bit per cycle
   logic             red_busy_ff, red_busy_in;
   logic [4:0]       red_cnt_ff, red_cnt_in;
   logic [SEQ_W:0]   red_num_ff, red_num_in;
   logic [SEQ_W:0]   red_rem_ff, red_rem_in;
   logic [SEQ_W-1:0] red_len_ff, red_len_in;
   logic             red_alt_ff, red_alt_in;

   logic                     accept;
   logic [6:0]               bits_eff;
   logic [7:0]               nbytes_wide;
   logic [MAX_CODE_BITS-1:0] code_masked;
   logic [SEQ_W-1:0]         len_eff;
   logic [SEQ_W:0]           seq_plus, seq_wrap, len_ext, rem_sh, rem_next;
   logic                     loop_mode, alt_mode;
   logic [7:0]               index_b, size_b;
   logic [15:0]              count_b;

   assign req_ready  = push_ready & ~red_busy_ff;
   assign csr_ready  = ~red_busy_ff;
   assign accept     = req_valid & req_ready;
   assign push_valid = accept;

   // effective code length and masked code
   always_comb begin
      bits_eff = code_bits_ff;
      if (code_bits_ff > 7'(MAX_CODE_BITS)) begin
         bits_eff = 7'(MAX_CODE_BITS);
      end
      nbytes_wide = {1'b0, bits_eff} + 8'd7;
      for (int i = 0; i < MAX_CODE_BITS; i++) begin
         code_masked[i] = code_ff[i] & (7'(i) < bits_eff);
      end
   end

   assign push_code = CODE_PAD_W'(code_masked);

   // counter step candidates
   assign len_eff  = (loop_len_ff == '0) ? 16'd1 : loop_len_ff;
   assign len_ext  = {1'b0, len_eff};
   assign seq_plus = {1'b0, seq_ff} + 17'd1;
   assign seq_wrap = seq_plus - len_ext;

   // header contents per mode
   always_comb begin
      index_b   = '0;
      size_b    = '0;
      count_b   = NO_COUNT;
      loop_mode = 1'b0;
      alt_mode  = 1'b0;
      unique case (mode_ff) inside
         phpf_pkg::MODE_INTERF: begin
            index_b = INTERF_INDEX;
            size_b  = INTERF_SIZE;
         end
         phpf_pkg::MODE_CLR_LOOP, phpf_pkg::MODE_INT_LOOP: begin
            loop_mode = 1'b1;
            count_b   = seq_ff;
            if (mode_ff == phpf_pkg::MODE_INT_LOOP) begin
               index_b = seq_ff[7:0];
               size_b  = len_eff[7:0];
            end
         end
         phpf_pkg::MODE_ALT_LOOP: begin
            loop_mode = 1'b1;
            alt_mode  = 1'b1;
            count_b   = seq_ff;
            if (phase_ff) begin
               index_b = seq_ff[7:0];
               size_b  = len_eff[7:0];
            end
         end
         default: begin
         end
      endcase
   end

   // transaction record for the back end
   always_comb begin
      push_cmd.data_byte     = req_data_byte;
      push_cmd.first         = req_first_of_packet;
      push_cmd.last          = req_last_of_packet;
      push_cmd.packet_length = req_packet_length;
      push_cmd.code_bytes    = phpf_pkg::NBYTES_W'(nbytes_wide >> 3);
      push_cmd.index_byte    = index_b;
      push_cmd.size_byte     = size_b;
      push_cmd.count         = count_b;
   end

   // one restoring modulo step
   always_comb begin
      rem_sh   = {red_rem_ff[SEQ_W-1:0], red_num_ff[SEQ_W]};
      rem_next = rem_sh;
      if (rem_sh >= {1'b0, red_len_ff}) begin
         rem_next = rem_sh - {1'b0, red_len_ff};
      end
   end

   // next state
   always_comb begin
      code_in     = code_ff;
      code_bits_in = code_bits_ff;
      mode_in     = mode_ff;
      loop_len_in = loop_len_ff;
      seq_in      = seq_ff;
      phase_in    = phase_ff;
      red_busy_in = red_busy_ff;
      red_cnt_in  = red_cnt_ff;
      red_num_in  = red_num_ff;
      red_rem_in  = red_rem_ff;
      red_len_in  = red_len_ff;
      red_alt_in  = red_alt_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            phpf_pkg::REG_ACCESS_CODE: code_in      = csr_data[MAX_CODE_BITS-1:0];
            phpf_pkg::REG_CODE_BITS:   code_bits_in = csr_data[6:0];
            phpf_pkg::REG_PREFIX_MODE: mode_in      = csr_data[2:0];
            phpf_pkg::REG_LOOP_LENGTH: loop_len_in  = csr_data[15:0];
            default: begin
            end
         endcase
      end

      // counter advance on a packet start
      if (accept && req_first_of_packet && loop_mode) begin
         if (seq_plus < len_ext) begin
            seq_in = seq_plus[SEQ_W-1:0];
         end else if (seq_wrap < len_ext) begin
            seq_in = seq_wrap[SEQ_W-1:0];
            if (alt_mode && (seq_wrap == '0)) begin
               phase_in = ~phase_ff;
            end
         end else begin
            red_busy_in = 1'b1;
            red_cnt_in  = RED_STEPS;
            red_num_in  = seq_plus;
            red_rem_in  = '0;
            red_len_in  = len_eff;
            red_alt_in  = alt_mode;
         end
      end

      // long remainder after the loop length shrank
      if (red_busy_ff) begin
         red_num_in = red_num_ff << 1;
         red_rem_in = rem_next;
         red_cnt_in = red_cnt_ff - 5'd1;
         if (red_cnt_ff == 5'd1) begin
            red_busy_in = 1'b0;
            seq_in      = rem_next[SEQ_W-1:0];
            if (red_alt_ff && (rem_next == '0)) begin
               phase_in = ~phase_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff      <= '0;
         code_bits_ff <= 7'd64;
         mode_ff      <= phpf_pkg::MODE_CLEAR;
         loop_len_ff  <= 16'd1;
         seq_ff       <= '0;
         phase_ff     <= 1'b0;
         red_busy_ff  <= 1'b0;
         red_cnt_ff   <= '0;
      end else begin
         code_ff      <= code_in;
         code_bits_ff <= code_bits_in;
         mode_ff      <= mode_in;
         loop_len_ff  <= loop_len_in;
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         red_busy_ff  <= red_busy_in;
         red_cnt_ff   <= red_cnt_in;
      end
      red_num_ff <= red_num_in;
      red_rem_ff <= red_rem_in;
      red_len_ff <= red_len_in;
      red_alt_ff <= red_alt_in;
   end

endmodule

// ----- rtl/phpf_queue.sv -----
// two-entry queue between front and back end
// no package dependency
module phpf_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_pop & out_valid;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- rtl/phpf_back.sv -----
// back end: walks one queued transaction byte by byte into the output register
// depends on phpf_pkg
module phpf_back #(
   parameter int  MAX_CODE_BITS = phpf_pkg::MAX_CODE_BITS_DEF,
   localparam int CODE_BYTES    = (MAX_CODE_BITS + 7) / 8,
   localparam int CODE_PAD_W    = CODE_BYTES * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  phpf_pkg::phpf_cmd_type q_cmd,
   input  logic [CODE_PAD_W-1:0]  q_code,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_header,
   output logic                   rsp_packet_end,
   output logic                   rsp_run_last
);

   logic [4:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       hdr_ff, hdr_in;
   logic       end_ff, end_in;
   logic       runl_ff, runl_in;

   logic                          adv, payload_step, at_code;
   logic [4:0]                    nb_ext, pay_pos;
   logic [2:0]                    fix_pos;
   logic [phpf_pkg::NBYTES_W-1:0] byte_sel;
   logic [7:0]                    code_byte, fix_byte;

   assign nb_ext       = 5'(q_cmd.code_bytes);
   assign pay_pos      = nb_ext + 5'(phpf_pkg::HDR_FIXED_BYTES);
   assign payload_step = ~q_cmd.first | (pos_ff == pay_pos);
   assign at_code      = (pos_ff < nb_ext);
   assign fix_pos      = 3'(pos_ff - nb_ext);
   assign byte_sel     = q_cmd.code_bytes - phpf_pkg::NBYTES_W'(1)
                         - pos_ff[phpf_pkg::NBYTES_W-1:0];
   assign adv          = q_valid & (~valid_ff | rsp_ready);
   assign q_pop        = adv & payload_step;

   // access code byte, most significant first
   always_comb begin
      code_byte = '0;
      for (int j = 0; j < CODE_BYTES; j++) begin
         if (phpf_pkg::NBYTES_W'(j) == byte_sel) begin
            code_byte = q_code[j*8 +: 8];
         end
      end
   end

   // fixed header bytes after the code
   always_comb begin
      case (fix_pos)
         3'd0:    fix_byte = q_cmd.index_byte;
         3'd1:    fix_byte = q_cmd.size_byte;
         3'd2:    fix_byte = q_cmd.packet_length[15:8];
         3'd3:    fix_byte = q_cmd.packet_length[7:0];
         3'd4:    fix_byte = q_cmd.packet_length[15:8];
         3'd5:    fix_byte = q_cmd.packet_length[7:0];
         3'd6:    fix_byte = q_cmd.count[15:8];
         default: fix_byte = q_cmd.count[7:0];
      endcase
   end

   // output register and byte position
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff & ~rsp_ready;
      byte_in  = byte_ff;
      hdr_in   = hdr_ff;
      end_in   = end_ff;
      runl_in  = runl_ff;
      if (adv) begin
         valid_in = 1'b1;
         runl_in  = payload_step;
         if (payload_step) begin
            pos_in  = '0;
            byte_in = q_cmd.data_byte;
            hdr_in  = 1'b0;
            end_in  = q_cmd.last;
         end else begin
            pos_in  = pos_ff + 5'd1;
            byte_in = at_code ? code_byte : fix_byte;
            hdr_in  = 1'b1;
            end_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      hdr_ff  <= hdr_in;
      end_ff  <= end_in;
      runl_ff <= runl_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_header  = hdr_ff;
   assign rsp_packet_end = end_ff;
   assign rsp_run_last   = runl_ff;

endmodule

// ----- rtl/phpf_checker.sv -----
// port-level checks for the framer core, bound to the top level
// depends on packet_header_prefix_framer_core
module phpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_header,
   input logic       rsp_packet_end,
   input logic       rsp_run_last
);

   // output register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // stalled transaction holds its byte and run-last mark
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last))
      else $error("rsp transaction changed while stalled");

   // header bytes never close a run
   a_hdr_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_header |-> !rsp_run_last && !rsp_packet_end)
      else $error("header byte marked as run end or packet end");

   // packet end falls on the last byte of a run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_run_last)
      else $error("packet end without run end");

   // a header byte taken is followed by more bytes of the same run
   a_hdr_then_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_header |=> !rsp_valid || rsp_is_header
         || rsp_run_last)
      else $error("run broken after header byte");

endmodule

bind packet_header_prefix_framer_core phpf_checker u_phpf_checker (.*);

// ----- tb/packet_header_prefix_framer_core_test.sv -----
// self-checking testbench for packet_header_prefix_framer_core
// predicts header and payload bytes per accepted transaction in a scoreboard class
// depends on phpf_pkg and the framer core rtl
`timescale 1ns / 100ps

// register indexes on the csr channel
typedef enum logic [phpf_pkg::CSR_INDEX_W-1:0] {
   REG_ACCESS_CODE = phpf_pkg::REG_ACCESS_CODE,
   REG_CODE_BITS   = phpf_pkg::REG_CODE_BITS,
   REG_PREFIX_MODE = phpf_pkg::REG_PREFIX_MODE,
   REG_LOOP_LENGTH = phpf_pkg::REG_LOOP_LENGTH,
   REG_SPARE_LOW   = 4'd4,
   REG_SPARE_HIGH  = 4'd15
} csr_reg_type;

// prefix modes, including two undefined codes
typedef enum logic [2:0] {
   MODE_CLEAR            = 3'(phpf_pkg::MODE_CLEAR),
   MODE_INTERFERING      = 3'(phpf_pkg::MODE_INTERF),
   MODE_CLEAR_LOOP       = 3'(phpf_pkg::MODE_CLR_LOOP),
   MODE_INTERFERING_LOOP = 3'(phpf_pkg::MODE_INT_LOOP),
   MODE_ALTERNATING_LOOP = 3'(phpf_pkg::MODE_ALT_LOOP),
   MODE_UNDEFINED_LOW    = 3'd5,
   MODE_UNDEFINED_HIGH   = 3'd7
} prefix_mode_type;

localparam int          CODE_BITS_LIMIT   = phpf_pkg::MAX_CODE_BITS_DEF;
localparam logic [7:0]  INTERFERING_INDEX = 8'h11;
localparam logic [7:0]  INTERFERING_SIZE  = 8'hff;
localparam logic [15:0] NO_COUNT          = 16'hffff;

typedef struct packed {
   logic [7:0] out_byte;
   logic       is_header;
   logic       packet_end;
   logic       run_last;
} framed_byte_type;

class frame_scoreboard;
   framed_byte_type expected_bytes[$];
   int unsigned     errors;
   logic [63:0]     access_code;
   logic [6:0]      code_bits;
   logic [2:0]      prefix_mode;
   logic [15:0]     loop_length;
   logic [15:0]     sequence_count;
   logic            alternate_phase;

   function new();
      errors          = 0;
      access_code     = '0;
      code_bits       = 7'd64;
      prefix_mode     = MODE_CLEAR;
      loop_length     = 16'd1;
      sequence_count  = '0;
      alternate_phase = 1'b0;
   endfunction

   function int unsigned pending_count();
      return expected_bytes.size();
   endfunction

   function void set_register(csr_reg_type idx, logic [63:0] value);
      case (idx)
         REG_ACCESS_CODE: access_code = value;
         REG_CODE_BITS:   code_bits = value[6:0];
         REG_PREFIX_MODE: prefix_mode = value[2:0];
         REG_LOOP_LENGTH: loop_length = value[15:0];
         default: ;
      endcase
   endfunction

   function void push_byte(logic [7:0] b, logic hdr, logic pend, logic rlast);
      framed_byte_type fb;
      fb.out_byte   = b;
      fb.is_header  = hdr;
      fb.packet_end = pend;
      fb.run_last   = rlast;
      expected_bytes.push_back(fb);
   endfunction

   // header (on a first byte) followed by the payload byte itself
   function void frame_input_byte(logic [7:0] data, logic first, logic last,
                                  logic [15:0] plen);
      int unsigned bits, code_bytes, i;
      logic [63:0] code;
      logic [15:0] modulus, count;
      logic [7:0]  index_b, size_b;
      if (first) begin
         bits = (code_bits > CODE_BITS_LIMIT) ? CODE_BITS_LIMIT : code_bits;
         code = access_code;
         if (bits < 64) code = code & ((64'd1 << bits) - 64'd1);
         code_bytes = (bits + 7) / 8;
         for (i = 0; i < code_bytes; i++)
            push_byte(8'(code >> (8 * (code_bytes - 1 - i))), 1'b1, 1'b0, 1'b0);

         modulus = (loop_length == 16'd0) ? 16'd1 : loop_length;
         index_b = 8'h00;
         size_b  = 8'h00;
         count   = NO_COUNT;
         case (prefix_mode) inside
            MODE_INTERFERING: begin
               index_b = INTERFERING_INDEX;
               size_b  = INTERFERING_SIZE;
            end
            MODE_CLEAR_LOOP, MODE_INTERFERING_LOOP, MODE_ALTERNATING_LOOP: begin
               if (prefix_mode == MODE_INTERFERING_LOOP ||
                   (prefix_mode == MODE_ALTERNATING_LOOP && alternate_phase)) begin
                  index_b = sequence_count[7:0];
                  size_b  = modulus[7:0];
               end
               count = sequence_count;
               sequence_count = 16'((32'(sequence_count) + 1) % 32'(modulus));
               // alternating loop flips phase each time the counter wraps
               if (prefix_mode == MODE_ALTERNATING_LOOP && sequence_count == 16'd0)
                  alternate_phase = ~alternate_phase;
            end
            default: ;
         endcase

         push_byte(index_b, 1'b1, 1'b0, 1'b0);
         push_byte(size_b, 1'b1, 1'b0, 1'b0);
         push_byte(plen[15:8], 1'b1, 1'b0, 1'b0);
         push_byte(plen[7:0], 1'b1, 1'b0, 1'b0);
         push_byte(plen[15:8], 1'b1, 1'b0, 1'b0);
         push_byte(plen[7:0], 1'b1, 1'b0, 1'b0);
         push_byte(count[15:8], 1'b1, 1'b0, 1'b0);
         push_byte(count[7:0], 1'b1, 1'b0, 1'b0);
      end
      push_byte(data, 1'b0, last, 1'b1);
   endfunction

   // compare one output transaction against the oldest expected byte
   function void check_output_byte(framed_byte_type got);
      framed_byte_type want;
      if (expected_bytes.size() == 0) begin
         errors++;
         $display("%0t: unexpected output, expected none, actual %02h hdr %b end %b last %b",
                  $time, got.out_byte, got.is_header, got.packet_end, got.run_last);
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
         errors++;
         $display("%0t: out_byte expected %02h actual %02h",
                  $time, want.out_byte, got.out_byte);
      end
      if (got.is_header !== want.is_header) begin
         errors++;
         $display("%0t: is_header expected %b actual %b",
                  $time, want.is_header, got.is_header);
      end
      if (got.packet_end !== want.packet_end) begin
         errors++;
         $display("%0t: packet_end expected %b actual %b",
                  $time, want.packet_end, got.packet_end);
      end
      if (got.run_last !== want.run_last) begin
         errors++;
         $display("%0t: run_last expected %b actual %b",
                  $time, want.run_last, got.run_last);
      end
   endfunction
endclass

module packet_header_prefix_framer_core_test;

   localparam int RANDOM_BYTES    = 500;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_first_of_packet = 1'b0;
   logic        req_last_of_packet = 1'b0;
   logic [15:0] req_packet_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_header;
   logic        rsp_packet_end;
   logic        rsp_run_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [phpf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [phpf_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   frame_scoreboard board;
   int unsigned     bytes_sent = 0;
   int unsigned     burst_left = 0;
   logic            steady = 1'b0;
   logic            hold_off_request = 1'b0;

   packet_header_prefix_framer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_first_of_packet(req_first_of_packet),
      .req_last_of_packet (req_last_of_packet),
      .req_packet_length  (req_packet_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_header      (rsp_is_header),
      .rsp_packet_end     (rsp_packet_end),
      .rsp_run_last       (rsp_run_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #6 clock = ~clock;

   // output side: check every accepted transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_output_byte({rsp_out_byte, rsp_is_header, rsp_packet_end, rsp_run_last});
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin : receiver
      int unsigned cyc;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_off_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            case ((cyc / 89) % 4)
               0: rsp_ready = 1'b1;
               1: rsp_ready = ($urandom_range(0, 3) != 0);
               2: rsp_ready = ((cyc % 3) != 0);
               default: rsp_ready = $urandom_range(0, 1);
            endcase
         end
      end
   end

   // watchdog: end the run after too many cycles with no transaction anywhere
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      wait (reset == 1'b0);
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic offer_byte(logic [7:0] data, logic first, logic last, logic [15:0] plen);
      @(negedge clock);
      req_valid           = 1'b1;
      req_data_byte       = data;
      req_first_of_packet = first;
      req_last_of_packet  = last;
      req_packet_length   = plen;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.frame_input_byte(data, first, last, plen);
      bytes_sent++;
   endtask

   // sender bursts with random gaps, unless running steady
   task automatic offer_paced(logic [7:0] data, logic first, logic last, logic [15:0] plen);
      int unsigned gap;
      if (burst_left == 0) begin
         if (!steady) begin
            gap = $urandom_range(1, 8);
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      offer_byte(data, first, last, plen);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [63:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // stop offering and wait for every expected byte to come out
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [63:0] value;
      int unsigned phase_index, phase_budget, pkt_len, i, random_end;
      board = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: eight zero code bytes, clear mode, zero length
      offer_byte(8'h00, 1'b1, 1'b1, 16'h0000);
      offer_byte(8'hff, 1'b0, 1'b0, 16'hffff);   // stray byte outside a packet
      wait_for_drain();

      // interfering mode, full code, maximum length, spare registers ignored
      write_reg(REG_ACCESS_CODE, 64'hf0e1_d2c3_b4a5_9687);
      write_reg(REG_PREFIX_MODE, MODE_INTERFERING);
      write_reg(REG_SPARE_LOW, '1);
      write_reg(REG_SPARE_HIGH, '1);
      offer_byte(8'hff, 1'b1, 1'b0, 16'hffff);
      offer_byte(8'h5a, 1'b0, 1'b0, 16'h1234);
      offer_byte(8'ha5, 1'b0, 1'b1, 16'h0000);
      wait_for_drain();

      // no code bytes, clear loop wrapping at three
      write_reg(REG_CODE_BITS, 64'd0);
      write_reg(REG_PREFIX_MODE, MODE_CLEAR_LOOP);
      write_reg(REG_LOOP_LENGTH, 64'd3);
      repeat (4) offer_byte($urandom_range(0, 255), 1'b1, 1'b1, $urandom_range(1, 65535));
      wait_for_drain();

      // oversized bit count, loop length zero, interfering loop
      write_reg(REG_CODE_BITS, 64'h7f);
      write_reg(REG_PREFIX_MODE, MODE_INTERFERING_LOOP);
      write_reg(REG_LOOP_LENGTH, 64'd0);
      repeat (2) offer_byte($urandom_range(0, 255), 1'b1, 1'b0, $urandom_range(1, 65535));
      wait_for_drain();

      // partial code byte masked, alternating loop toggling each wrap
      write_reg(REG_ACCESS_CODE, '1);
      write_reg(REG_CODE_BITS, 64'd13);
      write_reg(REG_PREFIX_MODE, MODE_ALTERNATING_LOOP);
      write_reg(REG_LOOP_LENGTH, 64'd2);
      repeat (5) offer_byte($urandom_range(0, 255), 1'b1, 1'b1, $urandom_range(1, 65535));
      wait_for_drain();

      // counter left beyond a shorter loop length
      write_reg(REG_PREFIX_MODE, MODE_CLEAR_LOOP);
      write_reg(REG_LOOP_LENGTH, 64'hffff);
      repeat (4) offer_byte($urandom_range(0, 255), 1'b1, 1'b1, 16'd1);
      wait_for_drain();
      write_reg(REG_LOOP_LENGTH, 64'd2);
      offer_byte($urandom_range(0, 255), 1'b1, 1'b1, 16'd1);
      wait_for_drain();

      // undefined modes behave as clear and keep the counter, single code bit
      write_reg(REG_CODE_BITS, 64'd1);
      write_reg(REG_PREFIX_MODE, MODE_UNDEFINED_LOW);
      offer_byte(8'h3c, 1'b1, 1'b1, 16'h00ff);
      wait_for_drain();
      write_reg(REG_PREFIX_MODE, MODE_UNDEFINED_HIGH);
      offer_byte(8'hc3, 1'b1, 1'b1, 16'hff00);

      // random phases, each with its own register settings
      random_end  = bytes_sent + RANDOM_BYTES;
      phase_index = 0;
      while (bytes_sent < random_end) begin
         wait_for_drain();

         if (phase_index == 0 || $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
               0: value = '0;
               1: value = '1;
               default: value = {$urandom, $urandom};
            endcase
            write_reg(REG_ACCESS_CODE, value);
         end
         if (phase_index == 0 || $urandom_range(0, 9) < 7) begin
            value = {$urandom, $urandom};
            case ($urandom_range(0, 19))
               0: value[6:0] = 7'd0;
               1: value[6:0] = $urandom_range(65, 127);
               2: value[6:0] = 7'd1;
               3: value[6:0] = 7'd64;
               default: value[6:0] = $urandom_range(1, 64);
            endcase
            write_reg(REG_CODE_BITS, value);
         end
         if (phase_index == 0 || $urandom_range(0, 9) < 8) begin
            value = {$urandom, $urandom};
            value[2:0] = ($urandom_range(0, 9) < 8)
                         ? $urandom_range(MODE_CLEAR, MODE_ALTERNATING_LOOP)
                         : $urandom_range(MODE_UNDEFINED_LOW, MODE_UNDEFINED_HIGH);
            write_reg(REG_PREFIX_MODE, value);
         end
         if (phase_index == 0 || $urandom_range(0, 9) < 7) begin
            value = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0: value[15:0] = 16'd0;
               1: value[15:0] = 16'hffff;
               2: value[15:0] = $urandom_range(0, 65535);
               3: value[15:0] = $urandom_range(250, 260);
               default: value[15:0] = $urandom_range(1, 12);
            endcase
            write_reg(REG_LOOP_LENGTH, value);
         end

         // one phase runs back to back against a long receiver hold-off
         steady     = (phase_index == 2) || ($urandom_range(0, 4) == 0);
         burst_left = 0;
         if (phase_index == 2) hold_off_request = 1'b1;

         phase_budget = $urandom_range(25, 70);
         while (phase_budget > 0) begin
            if ($urandom_range(0, 9) < 8) begin
               // well-formed packet with matching length
               pkt_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 6);
               for (i = 0; i < pkt_len; i++)
                  offer_paced($urandom_range(0, 255), i == 0, i == pkt_len - 1,
                              (i == 0) ? 16'(pkt_len) : 16'($urandom_range(0, 65535)));
               phase_budget = (phase_budget > pkt_len) ? phase_budget - pkt_len : 0;
            end else begin
               // noise: arbitrary marks and lengths
               case ($urandom_range(0, 3))
                  0: value[15:0] = 16'h0000;
                  1: value[15:0] = 16'hffff;
                  default: value[15:0] = $urandom_range(0, 65535);
               endcase
               offer_paced($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
                           value[15:0]);
               phase_budget--;
            end
         end
         phase_index++;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_count() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
